[design/qrm_pkg.sv]
// Package for the quaternion to rotation matrix block.
// Holds the component width, derived datapath widths and the shared sign-extension helper.
// No dependencies.
package qrm_pkg;

  localparam int CompW   = 16;
  localparam int ProdW   = 2 * CompW;
  localparam int RemW    = 2 * CompW + 2;
  localparam int QuotW   = 16;
  localparam int EntryW  = 16;
  localparam int NumEnt  = 9;
  localparam int NumStep = QuotW;
  localparam int InDataW = 4 * CompW;
  localparam int OutDataW = NumEnt * EntryW;

  localparam logic [EntryW-1:0] OneQ14 = EntryW'(16384);

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [RemW-1:0]   snum_t;
  typedef logic        [RemW-1:0]   rem_t;
  typedef logic        [QuotW-1:0]  quot_t;
  typedef logic        [EntryW-1:0] entry_t;

  function automatic snum_t sx(prod_t p);
    return snum_t'(p);
  endfunction

endpackage

[design/quaternion_to_rotation_matrix.sv]
// Top level of the quaternion to rotation matrix block.
// Products, sums, a sixteen-stage restoring divider per entry and a rounding stage.
// Depends on qrm_pkg.
//
//  Port group | Dir | Content
//  s_axis     | in  | tdata = x, y, z, w; tuser = present flag
//  m_axis     | out | tdata = entry0..entry8; tuser = identity fallback flag
//
// One quaternion is taken per cycle while the output is not stalled; its result passes
// through the products, the sums, one stage per quotient bit and the rounding, in that order.
// Reset clears the valid bits of every stage; payload registers are not reset.
// A stall on the output holds the whole pipeline, so nothing is lost or repeated.
module quaternion_to_rotation_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [qrm_pkg::InDataW-1:0]   s_axis_tdata,  // x, y, z, w from bit 0 up
  input  logic                          s_axis_tuser,  // quat_present
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [qrm_pkg::OutDataW-1:0]  m_axis_tdata,  // entry0 .. entry8 from bit 0 up
  output logic                          m_axis_tuser   // used_identity
);
  import qrm_pkg::*;

  logic  adv;
  comp_t cx, cy, cz, cw;

  logic  pv_q, pid_q;
  prod_t xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;

  logic  sv_q, sid_q;
  rem_t  sn_q;
  snum_t num_d [NumEnt];
  rem_t  sabs_q [NumEnt];
  logic  sneg_q [NumEnt];
  rem_t  n_sum;

  logic  dv_q   [NumStep];
  logic  did_q  [NumStep];
  rem_t  dn_q   [NumStep];
  rem_t  rem_q  [NumStep][NumEnt];
  quot_t quo_q  [NumStep][NumEnt];
  logic  dneg_q [NumStep][NumEnt];
  rem_t  rem_d  [NumStep][NumEnt];
  quot_t quo_d  [NumStep][NumEnt];

  logic  ov_q, oid_q;
  entry_t ent_q [NumEnt];

  // One restoring step: remainder in the upper bits, quotient in the lower bits.
  function automatic logic [RemW+QuotW-1:0] div_step(rem_t r, quot_t q, rem_t nd);
    if (r >= nd) begin
      return {rem_t'(r - nd), quot_t'(q | quot_t'(1))};
    end
    return {r, q};
  endfunction

  assign adv           = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign cx = comp_t'(s_axis_tdata[0*CompW +: CompW]);
  assign cy = comp_t'(s_axis_tdata[1*CompW +: CompW]);
  assign cz = comp_t'(s_axis_tdata[2*CompW +: CompW]);
  assign cw = comp_t'(s_axis_tdata[3*CompW +: CompW]);

  always_comb begin
    n_sum = rem_t'(sx(xx_q) + sx(yy_q) + sx(zz_q) + sx(ww_q));
    num_d[0] = sx(xx_q) + sx(ww_q) - sx(yy_q) - sx(zz_q);
    num_d[1] = (sx(xy_q) + sx(zw_q)) <<< 1;
    num_d[2] = (sx(xz_q) - sx(yw_q)) <<< 1;
    num_d[3] = (sx(xy_q) - sx(zw_q)) <<< 1;
    num_d[4] = sx(yy_q) + sx(ww_q) - sx(xx_q) - sx(zz_q);
    num_d[5] = (sx(yz_q) + sx(xw_q)) <<< 1;
    num_d[6] = (sx(xz_q) + sx(yw_q)) <<< 1;
    num_d[7] = (sx(yz_q) - sx(xw_q)) <<< 1;
    num_d[8] = sx(zz_q) + sx(ww_q) - sx(xx_q) - sx(yy_q);
  end

  always_comb begin
    for (int e = 0; e < NumEnt; e++) begin
      {rem_d[0][e], quo_d[0][e]} = div_step(sabs_q[e], '0, sn_q);
    end
    for (int k = 1; k < NumStep; k++) begin
      for (int e = 0; e < NumEnt; e++) begin
        {rem_d[k][e], quo_d[k][e]} =
          div_step(rem_q[k-1][e] << 1, quo_q[k-1][e] << 1, dn_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int k = 0; k < NumStep; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      pv_q <= s_axis_tvalid;
      sv_q <= pv_q;
      dv_q[0] <= sv_q;
      for (int k = 1; k < NumStep; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      ov_q <= dv_q[NumStep-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pid_q <= !s_axis_tuser;
      xx_q  <= cx * cx;
      yy_q  <= cy * cy;
      zz_q  <= cz * cz;
      ww_q  <= cw * cw;
      xy_q  <= cx * cy;
      zw_q  <= cz * cw;
      xz_q  <= cx * cz;
      yw_q  <= cy * cw;
      yz_q  <= cy * cz;
      xw_q  <= cx * cw;

      sid_q <= pid_q || (n_sum == '0);
      sn_q  <= n_sum;
      for (int e = 0; e < NumEnt; e++) begin
        sneg_q[e] <= num_d[e][RemW-1];
        sabs_q[e] <= num_d[e][RemW-1] ? rem_t'(-num_d[e]) : rem_t'(num_d[e]);
      end

      did_q[0] <= sid_q;
      dn_q[0]  <= sn_q;
      for (int e = 0; e < NumEnt; e++) begin
        rem_q[0][e]  <= rem_d[0][e];
        quo_q[0][e]  <= quo_d[0][e];
        dneg_q[0][e] <= sneg_q[e];
      end
      for (int k = 1; k < NumStep; k++) begin
        did_q[k] <= did_q[k-1];
        dn_q[k]  <= dn_q[k-1];
        for (int e = 0; e < NumEnt; e++) begin
          rem_q[k][e]  <= rem_d[k][e];
          quo_q[k][e]  <= quo_d[k][e];
          dneg_q[k][e] <= dneg_q[k-1][e];
        end
      end

      oid_q <= did_q[NumStep-1];
      for (int e = 0; e < NumEnt; e++) begin
        entry_t rnd;
        rnd = entry_t'((17'(quo_q[NumStep-1][e]) + 17'd1) >> 1);
        if (did_q[NumStep-1]) begin
          ent_q[e] <= (e == 0 || e == 4 || e == 8) ? OneQ14 : '0;
        end else begin
          ent_q[e] <= dneg_q[NumStep-1][e] ? entry_t'(-rnd) : rnd;
        end
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = oid_q;
  always_comb begin
    for (int e = 0; e < NumEnt; e++) begin
      m_axis_tdata[e*EntryW +: EntryW] = ent_q[e];
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_identity_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (ent_q[0] == OneQ14 && ent_q[4] == OneQ14 && ent_q[8] == OneQ14 && ent_q[1] == '0))
    else $error("identity fallback gave a wrong matrix");

  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(ent_q[0]) <= $signed(OneQ14) &&
                       $signed(ent_q[0]) >= -$signed(OneQ14)))
    else $error("diagonal entry out of range");

  a_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(ent_q[1])))
    else $error("stalled result changed");

endmodule

[tb/tb_quaternion_to_rotation_matrix.sv]
// Testbench for the quaternion to rotation matrix block.
// Drives quaternion transfers, predicts each matrix in fixed point and checks it.
// Depends on qrm_pkg and quaternion_to_rotation_matrix.
module tb_quaternion_to_rotation_matrix;
  timeunit 1ns;
  timeprecision 1ps;
  import qrm_pkg::*;

  typedef struct packed {
    logic [OutDataW-1:0] entries;
    logic                identity;
  } matrix_t;

  class matrix_scoreboard;
    matrix_t pending[$];
    int      errors = 0;

    function automatic entry_t round_ratio(longint num, longint n);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q   = ((mag << 15) / n + 1) >>> 1;
      return entry_t'((num < 0) ? -q : q);
    endfunction

    function void note_quat(logic present, logic [InDataW-1:0] data);
      longint x, y, z, w, n;
      matrix_t m;
      entry_t  e[NumEnt];
      x = longint'(comp_t'(data[0 +: CompW]));
      y = longint'(comp_t'(data[CompW +: CompW]));
      z = longint'(comp_t'(data[2*CompW +: CompW]));
      w = longint'(comp_t'(data[3*CompW +: CompW]));
      n = x*x + y*y + z*z + w*w;
      if (!present || n == 0) begin
        foreach (e[k]) e[k] = (k % 4 == 0) ? OneQ14 : '0;
        m.identity = 1'b1;
      end else begin
        e[0] = round_ratio(x*x + w*w - y*y - z*z, n);
        e[1] = round_ratio(2*(x*y + z*w), n);
        e[2] = round_ratio(2*(x*z - y*w), n);
        e[3] = round_ratio(2*(x*y - z*w), n);
        e[4] = round_ratio(y*y + w*w - x*x - z*z, n);
        e[5] = round_ratio(2*(y*z + x*w), n);
        e[6] = round_ratio(2*(x*z + y*w), n);
        e[7] = round_ratio(2*(y*z - x*w), n);
        e[8] = round_ratio(z*z + w*w - x*x - y*y, n);
        m.identity = 1'b0;
      end
      foreach (e[k]) m.entries[k*EntryW +: EntryW] = e[k];
      pending = {pending, m};
    endfunction

    function void check_matrix(logic [OutDataW-1:0] data, logic ident);
      matrix_t exp_m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, data);
        errors++;
        return;
      end
      exp_m = pending.pop_front();
      for (int k = 0; k < NumEnt; k++)
        if (data[k*EntryW +: EntryW] !== exp_m.entries[k*EntryW +: EntryW]) begin
          $display("%0t: entry%0d expected %0d actual %0d", $time, k,
                   $signed(exp_m.entries[k*EntryW +: EntryW]),
                   $signed(data[k*EntryW +: EntryW]));
          errors++;
        end
      if (ident !== exp_m.identity) begin
        $display("%0t: used_identity expected %b actual %b", $time, exp_m.identity, ident);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  matrix_scoreboard matrices = new();
  bit  sending_done = 0;
  bit  timed_out = 0;
  int  idle_cycles = 0;

  localparam int WatchdogLimit = 2000;

  always #5 clk_i = ~clk_i;

  quaternion_to_rotation_matrix i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) matrices.note_quat(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) matrices.check_matrix(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) timed_out = 1;
    end
  end

  function automatic comp_t pick_comp();
    case ($urandom_range(0, 7))
      0: return comp_t'(16'sh8000);
      1: return comp_t'(16'sh7fff);
      2: return '0;
      3: return comp_t'($urandom_range(0, 32) - 16);
      4: return comp_t'($urandom_range(0, 32768) - 16384);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic send_quat(logic present, comp_t x, comp_t y, comp_t z, comp_t w, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= present;
    s_axis_tdata  <= {w, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin : out_ready
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    comp_t edges[4];
    edges = '{comp_t'(16'sh8000), comp_t'(16'sh7fff), comp_t'(16'sh4000), comp_t'(16'sd1)};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_quat(1'b0, 16'sh1234, 16'sh7fff, 16'sh8000, 16'sh0001, 1'b0);
    send_quat(1'b1, '0, '0, '0, '0, 1'b0);
    send_quat(1'b0, '0, '0, '0, '0, 1'b0);
    send_quat(1'b1, '0, '0, '0, 16'sh4000, 1'b0);
    send_quat(1'b1, '0, '0, '0, 16'sd1, 1'b0);
    send_quat(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_quat(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_quat(1'b1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
    send_quat(1'b1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0);
    send_quat(1'b1, 16'sd1, '0, '0, '0, 1'b0);
    send_quat(1'b1, '0, 16'sd1, '0, '0, 1'b0);
    send_quat(1'b1, '0, '0, -16'sd1, '0, 1'b0);
    send_quat(1'b1, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0);
    for (int i = 0; i < 8; i++)
      send_quat(1'b1, edges[i % 4], edges[(i + 1) % 4], -edges[(i + 2) % 4],
                edges[(i + 3) % 4], 1'b0);
    for (int i = 0; i < 1700; i++)
      send_quat($urandom_range(0, 9) != 0, pick_comp(), pick_comp(), pick_comp(),
                pick_comp(), (i / 200) % 2 == 0);
    s_axis_tvalid <= 1'b0;
    sending_done = 1;
  end

  initial begin : finish_run
    while (!((sending_done && matrices.pending.size() == 0) || timed_out))
      @(posedge clk_i);
    if (!timed_out) repeat (40) @(posedge clk_i);
    if (!timed_out && matrices.errors == 0 && matrices.pending.size() == 0) begin
      $display("tb_quaternion_to_rotation_matrix: PASS");
    end else begin
      $display("tb_quaternion_to_rotation_matrix: FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
design/qrm_pkg.sv
design/quaternion_to_rotation_matrix.sv
tb/tb_quaternion_to_rotation_matrix.sv
